/* sv/rbpq_pkg.sv */
// ----------------------------------------------------------------------------
// rbpq_pkg
// Shared types, constants and arithmetic helpers for the beam position
// query unit.
// ----------------------------------------------------------------------------
package rbpq_pkg;

  localparam int TW        = 60;          // time word width
  localparam int NDIV      = TW;          // steps per divider, one quotient bit each
  localparam int NSTG      = 2 * NDIV;    // stages after the input register
  localparam int LATENCY   = NSTG + 2;    // accept edge to the edge that takes the result
  localparam int HW        = 11;          // screen height width
  localparam int LW        = 10;          // line field width
  localparam int PW        = 12;          // pixel field width
  localparam logic [HW-1:0] LINES_MAX = 11'd1024;
  localparam logic [PW-1:0] PIXEL_MAX = 12'hFFF;
  localparam logic [TW-1:0] TIME_MAX  = {TW{1'b1}};

  typedef enum logic [2:0] {
    REG_LINE_PERIOD   = 3'd0,
    REG_PIXEL_PERIOD  = 3'd1,
    REG_FRAME_PERIOD  = 3'd2,
    REG_SCREEN_LINES  = 3'd3,
    REG_VISIBLE_LEFT  = 3'd4,
    REG_VISIBLE_RIGHT = 3'd5,
    REG_VISIBLE_TOP   = 3'd6,
    REG_VISIBLE_BOT   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic          req;
    logic [TW-1:0] el;      // elapsed time
    logic [LW-1:0] tline;
    logic [PW-1:0] tpix;
    logic [TW-1:0] num;     // dividend bits still to shift in
    logic [TW-1:0] rem;     // partial remainder
    logic [HW-1:0] lmod;    // lines done, mod height
    logic [HW-1:0] base;    // (visible_bottom + 1) mod height
    logic [HW-1:0] tmod;    // target line mod height
    logic [PW-1:0] pixq;    // low pixel quotient bits
    logic          pixhi;   // pixel quotient above 12 bits
    logic [LW-1:0] bline;
    logic          vbl;
    logic [LW-1:0] rel;     // rebased target line
    logic [63:0]   pa;      // line product, later the target time
    logic [63:0]   pb;      // pixel product
    logic [TW-1:0] tu;      // time to target
  } stage_t;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [TW:0] div_step(input logic [TW-1:0] rem,
                                           input logic          nbit,
                                           input logic [TW-1:0] dvs);
    logic [TW:0] t;
    logic [TW:0] d;
    logic        ge;
    t  = {rem, nbit};
    d  = {1'b0, dvs};
    ge = (t >= d);
    div_step = ge ? {1'b1, TW'(t - d)} : {1'b0, t[TW-1:0]};
  endfunction

  // r = (2r + b) mod h, with r < h
  function automatic logic [HW-1:0] mod_step(input logic [HW-1:0] r,
                                             input logic          b,
                                             input logic [HW-1:0] h);
    logic [HW:0] t;
    t = {r, b};
    mod_step = (t >= {1'b0, h}) ? HW'(t - {1'b0, h}) : t[HW-1:0];
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    add_sat = s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

/* sv/raster_beam_position_query_unit.sv */
// ----------------------------------------------------------------------------
// raster_beam_position_query_unit
// Beam line, pixel, blank flags and time until a target position, from the
// time elapsed since vertical blank.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+------------------------
//  request  | req_type_i elapsed_time_i target_*_i      | start_i && !busy_o
//  result   | beam_*_o in_vblank_o in_hblank_o time_... | valid_o, one cycle
//  config   | cfg_index_i cfg_data_i                    | cfg_valid_i && cfg_ready_o
//
//  One word enters per cycle; busy_o stays low. Each result passes one input
//  register, then two chained 60-step restoring dividers (elapsed /
//  line_period, then remainder / pixel_period), one quotient bit per stage,
//  then the output register.
//  Line mod height, rebasing, products and frame wrap ride along in the
//  same stages. Reset clears the valid bits, sets periods and height to 1
//  and clears the bounds; results cannot be held off, so the pipe never stalls.
//
module raster_beam_position_query_unit
  import rbpq_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic          req_type_i,
  input  logic [59:0]   elapsed_time_i,
  input  logic [9:0]    target_line_i,
  input  logic [11:0]   target_pixel_i,
  output logic          valid_o,
  output logic [9:0]    beam_line_o,
  output logic [11:0]   beam_pixel_o,
  output logic          in_vblank_o,
  output logic          in_hblank_o,
  output logic [59:0]   time_until_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [59:0]   cfg_data_i
);

  // config registers
  logic [TW-1:0] line_period_q, pixel_period_q, frame_period_q;
  logic [HW-1:0] screen_lines_q;
  logic [PW-1:0] visible_left_q, visible_right_q;
  logic [LW-1:0] visible_top_q, visible_bottom_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_period_q    <= TW'(1);
      pixel_period_q   <= TW'(1);
      frame_period_q   <= TW'(1);
      screen_lines_q   <= HW'(1);
      visible_left_q   <= '0;
      visible_right_q  <= '0;
      visible_top_q    <= '0;
      visible_bottom_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_LINE_PERIOD:   line_period_q    <= cfg_data_i;
        REG_PIXEL_PERIOD:  pixel_period_q   <= cfg_data_i;
        REG_FRAME_PERIOD:  frame_period_q   <= cfg_data_i;
        REG_SCREEN_LINES:  screen_lines_q   <= cfg_data_i[HW-1:0];
        REG_VISIBLE_LEFT:  visible_left_q   <= cfg_data_i[PW-1:0];
        REG_VISIBLE_RIGHT: visible_right_q  <= cfg_data_i[PW-1:0];
        REG_VISIBLE_TOP:   visible_top_q    <= cfg_data_i[LW-1:0];
        REG_VISIBLE_BOT:   visible_bottom_q <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // zero periods act as one; height clamps to 1..1024
  logic [TW-1:0] lp, pp, fp;
  logic [HW-1:0] hn;
  logic [HW-1:0] vb1;   // visible_bottom + 1

  always_comb begin
    lp  = (line_period_q  == '0) ? TW'(1) : line_period_q;
    pp  = (pixel_period_q == '0) ? TW'(1) : pixel_period_q;
    fp  = (frame_period_q == '0) ? TW'(1) : frame_period_q;
    hn  = (screen_lines_q == '0) ? HW'(1) :
          (screen_lines_q > LINES_MAX) ? LINES_MAX : screen_lines_q;
    vb1 = {1'b0, visible_bottom_q} + HW'(1);
  end

  // pipeline
  stage_t stg_q [0:NSTG];
  stage_t stg_d [1:NSTG];
  stage_t stg0_d;
  logic [NSTG:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-1:0], start_i && !busy_o};
    end
  end

  always_comb begin
    stg0_d       = '0;
    stg0_d.req   = req_type_i;
    stg0_d.el    = elapsed_time_i;
    stg0_d.tline = target_line_i;
    stg0_d.tpix  = target_pixel_i;
    stg0_d.num   = elapsed_time_i;
  end

  always_ff @(posedge clk_i) begin
    stg_q[0] <= stg0_d;
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    localparam int BI = (s < HW) ? (HW - 1 - s) : 0;

    always_comb begin
      stage_t        cur;
      stage_t        nxt;
      logic [TW:0]   dv;
      logic [HW:0]   lsum;
      logic [HW-1:0] lfin;
      logic [HW-1:0] tl11;
      logic [69:0]   m1;
      logic [71:0]   m2;
      logic [63:0]   el64;
      logic [63:0]   diff;
      cur  = stg_q[s];
      nxt  = cur;
      lsum = '0;
      lfin = '0;
      m1   = '0;
      m2   = '0;
      diff = '0;
      tl11 = {1'b0, cur.tline};
      el64 = {4'b0, cur.el};

      if (s < NDIV) begin
        // elapsed / line_period; quotient bits feed the line counter mod height
        dv       = div_step(cur.rem, cur.num[TW-1], lp);
        nxt.rem  = dv[TW-1:0];
        nxt.num  = {cur.num[TW-2:0], 1'b0};
        nxt.lmod = mod_step(cur.lmod, dv[TW], hn);
        if (s == NDIV - 1) begin
          nxt.num = dv[TW-1:0];
          nxt.rem = '0;
        end
      end else begin
        // remainder / pixel_period; keep 12 bits plus overflow flag
        dv        = div_step(cur.rem, cur.num[TW-1], pp);
        nxt.rem   = dv[TW-1:0];
        nxt.num   = {cur.num[TW-2:0], 1'b0};
        nxt.pixq  = {cur.pixq[PW-2:0], dv[TW]};
        nxt.pixhi = cur.pixhi | cur.pixq[PW-1];
      end

      if (s < HW) begin
        nxt.base = mod_step(cur.base, vb1[BI], hn);
        nxt.tmod = mod_step(cur.tmod, tl11[BI], hn);
      end

      if (s == NDIV) begin
        lsum      = {1'b0, cur.lmod} + {1'b0, cur.base};
        lfin      = (lsum >= {1'b0, hn}) ? HW'(lsum - {1'b0, hn}) : lsum[HW-1:0];
        nxt.bline = lfin[LW-1:0];
        nxt.vbl   = (lfin < {1'b0, visible_top_q}) || (lfin > {1'b0, visible_bottom_q});
        nxt.rel   = (cur.tmod >= cur.base) ? LW'(cur.tmod - cur.base)
                                           : LW'(cur.tmod + hn - cur.base);
      end

      if (s == NDIV + 1) begin
        m1     = 70'(cur.rel) * 70'(lp);
        m2     = 72'(cur.tpix) * 72'(pp);
        nxt.pa = (|m1[69:64]) ? {64{1'b1}} : m1[63:0];
        nxt.pb = (|m2[71:64]) ? {64{1'b1}} : m2[63:0];
      end

      if (s == NDIV + 2) begin
        nxt.pa = add_sat(cur.pa, cur.pb);
      end

      if (s == NDIV + 3) begin
        // point already passed: next frame
        if (cur.pa <= el64) nxt.pa = add_sat(cur.pa, {4'b0, fp});
      end

      if (s == NDIV + 4) begin
        diff = cur.pa - el64;
        if (!cur.req || cur.pa <= el64) begin
          nxt.tu = '0;
        end else begin
          nxt.tu = (|diff[63:TW]) ? TIME_MAX : diff[TW-1:0];
        end
      end

      stg_d[s+1] = nxt;
    end

    always_ff @(posedge clk_i) begin
      stg_q[s+1] <= stg_d[s+1];
    end
  end

  // output register
  logic          valid_q;
  logic [LW-1:0] beam_line_q;
  logic [PW-1:0] beam_pixel_q;
  logic          vbl_q, hbl_q;
  logic [TW-1:0] tu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    beam_line_q  <= stg_q[NSTG].bline;
    beam_pixel_q <= stg_q[NSTG].pixhi ? PIXEL_MAX : stg_q[NSTG].pixq;
    vbl_q        <= stg_q[NSTG].vbl;
    hbl_q        <= stg_q[NSTG].pixhi ||
                    (stg_q[NSTG].pixq < visible_left_q) ||
                    (stg_q[NSTG].pixq > visible_right_q);
    tu_q         <= stg_q[NSTG].tu;
  end

  assign valid_o      = valid_q;
  assign beam_line_o  = beam_line_q;
  assign beam_pixel_o = beam_pixel_q;
  assign in_vblank_o  = vbl_q;
  assign in_hblank_o  = hbl_q;
  assign time_until_o = tu_q;

endmodule

/* sv/rbpq_checker.sv */
// ----------------------------------------------------------------------------
// rbpq_checker
// Port-level timing checks for the beam position query unit.
// ----------------------------------------------------------------------------
module rbpq_checker
  import rbpq_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        req_type_i,
  input logic        valid_o,
  input logic [59:0] time_until_o
);

  a_start_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY valid_o)
    else $error("result strobe missing after start");

  a_result_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result strobe without start");

  a_position_zero_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && time_until_o != '0) |-> $past(req_type_i, LATENCY))
    else $error("nonzero time on position query");

endmodule

bind raster_beam_position_query_unit rbpq_checker u_rbpq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .req_type_i   (req_type_i),
  .valid_o      (valid_o),
  .time_until_o (time_until_o)
);
